// File: rtl/core/sorted_union_dedup_macros.svh
// Assertion macros shared by the checkers of this block.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef SORTED_UNION_DEDUP_MACROS_SVH
`define SORTED_UNION_DEDUP_MACROS_SVH

// Same-cycle implication.
`define SUD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_union_dedup check failed");

// Next-cycle implication.
`define SUD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_union_dedup check failed");

`endif

// File: rtl/core/sud_pkg.sv
package sud_pkg;

    // Capacity of the value store for one batch.
    localparam int MAX_ITEMS = 8;
    localparam int VAL_W     = 32;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SCAN = 3'b010,
        S_PUSH = 3'b100
    } t_state;

endpackage

// File: rtl/core/sud_ram.sv
module sud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/sorted_union_dedup.sv
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_ready  i_item_value, i_batch_end
// out       output     o_out_valid / i_out_ready o_union_value, o_run_end, o_dropped_items
//
// A batch end starts a search: a batch with d distinct values takes d + 1 scans, each of
// which reads the n stored entries through the single read port of the store, and every
// distinct value found goes through S_PUSH to the output register.
// Reset is synchronous and active low; the store itself is not cleared.
// A stalled output holds the search at its next result; loading resumes once the last
// result of the batch sits in the output register.
module sorted_union_dedup (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [sud_pkg::VAL_W-1:0]   i_item_value,
    input  logic                               i_batch_end,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [sud_pkg::VAL_W-1:0]   o_union_value,
    output logic                               o_run_end,
    output logic                               o_dropped_items
);

    sud_pkg::t_state                   r_state, n_state;
    logic [sud_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [sud_pkg::CNT_W-1:0]         r_ra, n_ra;
    logic                              r_rv, n_rv;
    logic                              r_ovf, n_ovf;
    logic signed [sud_pkg::VAL_W-1:0]  r_best, n_best;
    logic                              r_best_vld, n_best_vld;
    logic signed [sud_pkg::VAL_W-1:0]  r_pend, n_pend;
    logic                              r_pend_vld, n_pend_vld;
    logic                              r_out_valid, n_out_valid;
    logic signed [sud_pkg::VAL_W-1:0]  r_out_value, n_out_value;
    logic                              r_out_end, n_out_end;
    logic                              r_out_drop, n_out_drop;

    logic                              in_acc;
    logic                              room;
    logic                              out_free;
    logic                              above;
    logic                              better;
    logic [sud_pkg::VAL_W-1:0]         rd_data;
    logic signed [sud_pkg::VAL_W-1:0]  q;

    assign o_in_ready      = (r_state == sud_pkg::S_LOAD);
    assign in_acc          = i_in_valid && o_in_ready;
    assign room            = (r_cnt < sud_pkg::CNT_W'(sud_pkg::MAX_ITEMS));
    assign out_free        = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_union_value   = r_out_value;
    assign o_run_end       = r_out_end;
    assign o_dropped_items = r_out_drop;

    sud_ram #(
        .WIDTH (sud_pkg::VAL_W),
        .DEPTH (sud_pkg::MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && room),
        .i_waddr (r_cnt[sud_pkg::ADDR_W-1:0]),
        .i_wdata (i_item_value),
        .i_raddr (r_ra[sud_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign q = rd_data;

    // The shared compare unit: an entry is a candidate if it lies above the last value
    // found, and it wins if it lies below the best candidate so far.
    assign above  = !r_pend_vld || (q > r_pend);
    assign better = !r_best_vld || (q < r_best);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ra        = r_ra;
        n_rv        = 1'b0;
        n_ovf       = r_ovf;
        n_best      = r_best;
        n_best_vld  = r_best_vld;
        n_pend      = r_pend;
        n_pend_vld  = r_pend_vld;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_end   = r_out_end;
        n_out_drop  = r_out_drop;

        unique case (r_state)
            sud_pkg::S_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_batch_end) begin
                        n_state    = sud_pkg::S_SCAN;
                        n_ra       = '0;
                        n_best_vld = 1'b0;
                        n_pend_vld = 1'b0;
                    end
                end
            end
            sud_pkg::S_SCAN: begin
                if (r_ra < r_cnt) begin
                    n_ra = r_ra + 1'b1;
                    n_rv = 1'b1;
                end
                if (r_rv && above && better) begin
                    n_best     = q;
                    n_best_vld = 1'b1;
                end
                if (!r_rv && (r_ra == r_cnt)) begin
                    if (r_best_vld && !r_pend_vld) begin
                        // First value of the batch: nothing to hand out yet, search again.
                        n_pend     = r_best;
                        n_pend_vld = 1'b1;
                        n_best_vld = 1'b0;
                        n_ra       = '0;
                    end else begin
                        n_state = sud_pkg::S_PUSH;
                    end
                end
            end
            sud_pkg::S_PUSH: begin
                if (out_free) begin
                    // No new candidate means the held value is the largest of the batch.
                    n_out_valid = 1'b1;
                    n_out_value = r_pend;
                    n_out_end   = !r_best_vld;
                    n_out_drop  = r_ovf;
                    if (r_best_vld) begin
                        n_pend     = r_best;
                        n_best_vld = 1'b0;
                        n_ra       = '0;
                        n_state    = sud_pkg::S_SCAN;
                    end else begin
                        n_cnt      = '0;
                        n_ovf      = 1'b0;
                        n_pend_vld = 1'b0;
                        n_state    = sud_pkg::S_LOAD;
                    end
                end
            end
            default: begin
                n_state = sud_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sud_pkg::S_LOAD;
            r_cnt       <= '0;
            r_ra        <= '0;
            r_rv        <= 1'b0;
            r_ovf       <= 1'b0;
            r_best_vld  <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ra        <= n_ra;
            r_rv        <= n_rv;
            r_ovf       <= n_ovf;
            r_best_vld  <= n_best_vld;
            r_pend_vld  <= n_pend_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best      <= n_best;
        r_pend      <= n_pend;
        r_out_value <= n_out_value;
        r_out_end   <= n_out_end;
        r_out_drop  <= n_out_drop;
    end

endmodule

// File: rtl/core/sud_chk.sv
`include "sorted_union_dedup_macros.svh"

module sud_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic signed [sud_pkg::VAL_W-1:0] i_item_value,
    input logic                             i_batch_end,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic signed [sud_pkg::VAL_W-1:0] o_union_value,
    input logic                             o_run_end,
    input logic                             o_dropped_items
);

    // A stalled result keeps its value and marks.
    `SUD_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_union_value) && $stable(o_run_end) && $stable(o_dropped_items))

    // The end of a batch closes the input until its results are out.
    `SUD_ASSERT_NXT(a_batch_closes, i_in_valid && o_in_ready && i_batch_end, !o_in_ready)

    // An ordinary item leaves the input open for the next request.
    `SUD_ASSERT_NXT(a_load_open, i_in_valid && o_in_ready && !i_batch_end, o_in_ready)

    // Only the final result of a batch may wait while new requests are taken.
    `SUD_ASSERT_IMP(a_mid_run_busy, o_out_valid && !o_run_end, !o_in_ready)

endmodule

bind sorted_union_dedup sud_chk u_sud_chk (.*);

// File: test/tb_sorted_union_dedup.sv
module tb_sorted_union_dedup;
    import sud_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 160;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    run_end;
        logic                    dropped;
    } t_union_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [VAL_W-1:0] i_item_value = '0;
    logic                    i_batch_end = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VAL_W-1:0] o_union_value;
    logic                    o_run_end;
    logic                    o_dropped_items;

    // Shadow of the batch held by the block.
    logic signed [VAL_W-1:0] batch_values[$];
    logic                    batch_overflow = 1'b0;
    t_union_result           pending_union[$];

    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;
    int error_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int batches_sent = 0;
    int overflow_batches = 0;
    int results_checked = 0;

    sorted_union_dedup i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_item_value   (i_item_value),
        .i_batch_end    (i_batch_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_union_value  (o_union_value),
        .o_run_end      (o_run_end),
        .o_dropped_items(o_dropped_items)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_union.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic signed [VAL_W-1:0] got,
                                   input logic signed [VAL_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // Stores one value and, on a batch end, queues the sorted distinct values.
    task automatic predict_union(input logic signed [VAL_W-1:0] value, input logic last);
        logic signed [VAL_W-1:0] sorted_vals[$];
        logic signed [VAL_W-1:0] distinct_vals[$];
        t_union_result           entry;
        int                      pos;
        if (batch_values.size() < MAX_ITEMS)
            batch_values.push_back(value);
        else
            batch_overflow = 1'b1;
        if (!last)
            return;
        foreach (batch_values[k]) begin
            pos = 0;
            while (pos < sorted_vals.size() && sorted_vals[pos] <= batch_values[k])
                pos++;
            sorted_vals.insert(pos, batch_values[k]);
        end
        foreach (sorted_vals[k])
            if (k == 0 || sorted_vals[k] != sorted_vals[k-1])
                distinct_vals.push_back(sorted_vals[k]);
        foreach (distinct_vals[k]) begin
            entry.value   = distinct_vals[k];
            entry.run_end = (k == distinct_vals.size() - 1);
            entry.dropped = batch_overflow;
            pending_union.push_back(entry);
        end
        batches_sent++;
        if (batch_overflow)
            overflow_batches++;
        batch_values.delete();
        batch_overflow = 1'b0;
    endtask

    // Valid stays high across back-to-back requests; it drops only for a gap.
    task automatic send_item(input logic signed [VAL_W-1:0] value, input logic last);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_item_value <= value;
        i_batch_end  <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_union(value, last);
        items_sent++;
    endtask

    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            stall = out_idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid)
                @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_union_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_union.size() == 0) begin
                report_mismatch("unexpected result", o_union_value, 0);
            end else begin
                want = pending_union.pop_front();
                results_checked++;
                if (o_union_value !== want.value)
                    report_mismatch("union_value", o_union_value, want.value);
                if (o_run_end !== want.run_end)
                    report_mismatch("run_end", o_run_end, want.run_end);
                if (o_dropped_items !== want.dropped)
                    report_mismatch("dropped_items", o_dropped_items, want.dropped);
            end
        end
    end

    task automatic test_single_value();
        send_item(0, 1'b1);
    endtask

    // Fills the store exactly, with both extremes and repeated values out of order.
    task automatic test_extreme_values();
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b0);
        send_item(1, 1'b0);
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sh55555555, 1'b1);
    endtask

    task automatic test_all_duplicates();
        repeat (3) send_item(32'shA5A5A5A5, 1'b0);
        send_item(32'shA5A5A5A5, 1'b1);
    endtask

    // The batch end arrives on a full store, so it is dropped itself.
    task automatic test_overflow();
        for (int k = 0; k < MAX_ITEMS; k++)
            send_item(MAX_ITEMS - k, 1'b0);
        send_item(-7, 1'b1);
    endtask

    task automatic test_random_batches();
        int                      sent;
        int                      size;
        logic signed [VAL_W-1:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            size = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4)
                                               : $urandom_range(1, MAX_ITEMS);
            for (int k = 0; k < size; k++) begin
                case ($urandom_range(0, 3))
                    0: value = $urandom;
                    1: value = int'($urandom_range(0, 6)) - 3;
                    2: value = $urandom_range(0, 1) ? 32'sh7fffffff - int'($urandom_range(0, 2))
                                                    : 32'sh80000000 + int'($urandom_range(0, 2));
                    default: value = int'($urandom_range(0, 40)) - 20;
                endcase
                send_item(value, k == size - 1);
            end
            sent += size;
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_value();
        test_extreme_values();
        test_all_duplicates();
        test_overflow();
        test_random_batches();
        i_in_valid <= 1'b0;
        while (pending_union.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("%0d requests in %0d batches (%0d with dropped items), %0d results checked",
                 items_sent, batches_sent, overflow_batches, results_checked);
        $display("%0d mismatches", error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
